/* design/rmq_pkg.sv */
// ----------------------------------------------------------------------------
// rmq_pkg: shared constants for the rotation matrix to quaternion converter
// Field widths, case codes and divider sizing.
// ----------------------------------------------------------------------------
package rmq_pkg;

  localparam int FRAC_BITS_DEF = 14;
  localparam int FIELD_W       = 16;
  // quotient bits resolved by the divider; anything above is overflow
  localparam int DIV_QBITS     = 17;

  localparam logic [1:0] CASE_TRACE = 2'd0;
  localparam logic [1:0] CASE_X     = 2'd1;
  localparam logic [1:0] CASE_Y     = 2'd2;
  localparam logic [1:0] CASE_Z     = 2'd3;

endpackage

/* design/rmq_div.sv */
// ----------------------------------------------------------------------------
// rmq_div: pipelined rounding divider
// q = floor((mag * 2^(F+1) + 2s) / 4s), one quotient bit per stage, with an
// overflow flag for quotients of 2^DIV_QBITS and above.
// ----------------------------------------------------------------------------
module rmq_div #(
  parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF,
  parameter int SW        = FRAC_BITS + 9
) (
  input  logic                           clk,
  input  logic                           en,
  input  logic [rmq_pkg::FIELD_W:0]      mag,
  input  logic [SW-1:0]                  root,
  output logic [rmq_pkg::DIV_QBITS-1:0]  quot,
  output logic                           ovf
);

  localparam int QB = rmq_pkg::DIV_QBITS;
  localparam int NW = SW + 20;
  localparam int DW = SW + 2;

  logic [NW-1:0] num_w;
  logic [NW-1:0] den_w;

  logic [NW-1:0] rem_r [0:QB-1];
  logic [DW-1:0] d_r   [0:QB-1];
  logic [QB-1:0] q_r   [1:QB];
  logic          ovf_r [0:QB];

  assign num_w = (NW'(mag) << (FRAC_BITS + 1)) + NW'({root, 1'b0});
  assign den_w = NW'({root, 2'b00});

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= num_w;
      d_r[0]   <= den_w[DW-1:0];
      ovf_r[0] <= num_w >= (den_w << QB);
    end
  end

  for (genvar i = 0; i < QB; i++) begin : g_stage
    logic [QB-1:0] q_in;
    logic [NW-1:0] sub_w;
    logic          take_w;

    if (i == 0) begin : g_first
      assign q_in = '0;
    end else begin : g_next
      assign q_in = q_r[i];
    end

    assign sub_w  = NW'(d_r[i]) << (QB - 1 - i);
    assign take_w = rem_r[i] >= sub_w;

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[i+1]   <= {q_in[QB-2:0], take_w};
        ovf_r[i+1] <= ovf_r[i];
      end
    end

    if (i < QB - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[i+1] <= take_w ? rem_r[i] - sub_w : rem_r[i];
          d_r[i+1]   <= d_r[i];
        end
      end
    end
  end

  assign quot = q_r[QB];
  assign ovf  = ovf_r[QB];

endmodule

/* design/rotation_matrix_to_quaternion.sv */
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion: Shepperd conversion, fixed point
// Case select and radicand, bit-serial pipelined square root, three
// pipelined rounding dividers, saturation.
// ----------------------------------------------------------------------------
// Pipeline: 1 select stage, FRAC_BITS+9 root stages (one root bit each), 1 divider
//   setup stage, 17 divider stages (one quotient bit each), 1 output stage.
// Throughput: one beat per cycle; the whole pipe stalls while out is blocked.
// Reset: synchronous active-low rst_n clears the valid bits only.
module rotation_matrix_to_quaternion #(
  parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // ax_x, ax_y, ax_z, ay_x, ay_y, ay_z, az_x, az_y, az_z (16 b each)
  input  logic [143:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // quat_x, quat_y, quat_z, quat_w (16 b each)
  output logic [63:0]  out_tdata,
  // case_used [1:0], saturated [2]
  output logic [2:0]   out_tuser
);

  localparam int FW  = rmq_pkg::FIELD_W;
  localparam int SW  = FRAC_BITS + 9;
  localparam int VW  = 2 * SW;
  localparam int RW  = FRAC_BITS + 19;
  localparam int DL  = rmq_pkg::DIV_QBITS + 1;
  localparam int EW  = FW + 3;

  logic adv;
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  // ---------------- select stage ----------------
  logic signed [EW-1:0] xx, xy, xz, yx, yy, yz, zx, zy, zz, tr;
  logic signed [RW-1:0] rad_w;
  logic signed [FW:0]   n_w [3];
  logic [1:0]           cs_w;

  assign xx = EW'($signed(in_tdata[15:0]));
  assign xy = EW'($signed(in_tdata[31:16]));
  assign xz = EW'($signed(in_tdata[47:32]));
  assign yx = EW'($signed(in_tdata[63:48]));
  assign yy = EW'($signed(in_tdata[79:64]));
  assign yz = EW'($signed(in_tdata[95:80]));
  assign zx = EW'($signed(in_tdata[111:96]));
  assign zy = EW'($signed(in_tdata[127:112]));
  assign zz = EW'($signed(in_tdata[143:128]));
  assign tr = xx + yy + zz;

  always_comb begin
    logic signed [EW-1:0] comb;
    logic signed [EW-1:0] a0, a1, a2;
    if (tr > 0) begin
      cs_w = rmq_pkg::CASE_TRACE;
      comb = tr;
      a0 = yz - zy; a1 = zx - xz; a2 = xy - yx;
    end else if (xx > yy && xx > zz) begin
      cs_w = rmq_pkg::CASE_X;
      comb = xx - yy - zz;
      a0 = yz - zy; a1 = yx + xy; a2 = zx + xz;
    end else if (yy > zz) begin
      cs_w = rmq_pkg::CASE_Y;
      comb = yy - xx - zz;
      a0 = zx - xz; a1 = yx + xy; a2 = zy + yz;
    end else begin
      cs_w = rmq_pkg::CASE_Z;
      comb = zz - xx - yy;
      a0 = xy - yx; a1 = zx + xz; a2 = zy + yz;
    end
    rad_w  = (RW'(1) << FRAC_BITS) + RW'(comb);
    n_w[0] = a0[FW:0];
    n_w[1] = a1[FW:0];
    n_w[2] = a2[FW:0];
  end

  // side data traveling alongside the root pipeline
  logic [SW:0]   vld_r;
  logic [1:0]    cs_r   [0:SW];
  logic          rz_r   [0:SW];
  logic [2:0]    neg_r  [0:SW];
  logic [FW:0]   mag_r  [0:SW][3];
  logic [VW-1:0] v_r    [0:SW-1];
  logic [SW:0]   rem_r  [1:SW-1];
  logic [SW-1:0] root_r [1:SW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[SW-1:0], in_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cs_r[0] <= cs_w;
      rz_r[0] <= rad_w <= 0;
      v_r[0]  <= (rad_w <= 0) ? '0 : {rad_w[FRAC_BITS+17:0], {FRAC_BITS{1'b0}}};
      for (int k = 0; k < 3; k++) begin
        neg_r[0][k] <= n_w[k][FW];
        mag_r[0][k] <= n_w[k][FW] ? -n_w[k] : n_w[k];
      end
    end
  end

  // ---------------- square root, one bit per stage ----------------
  for (genvar j = 0; j < SW; j++) begin : g_sqrt
    logic [SW:0]   rem_in;
    logic [SW-1:0] root_in;
    logic [SW+2:0] cat_w, trial_w, diff_w;
    logic          take_w;

    if (j == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_r[j];
      assign root_in = root_r[j];
    end

    assign cat_w   = {rem_in, v_r[j][VW-1-2*j -: 2]};
    assign trial_w = (SW+3)'({root_in, 2'b01});
    assign take_w  = cat_w >= trial_w;
    assign diff_w  = cat_w - trial_w;

    always_ff @(posedge clk) begin
      if (adv) begin
        root_r[j+1] <= {root_in[SW-2:0], take_w};
        cs_r[j+1]   <= cs_r[j];
        rz_r[j+1]   <= rz_r[j];
        neg_r[j+1]  <= neg_r[j];
        mag_r[j+1]  <= mag_r[j];
      end
    end

    if (j < SW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (adv) begin
          rem_r[j+1] <= take_w ? diff_w[SW:0] : cat_w[SW:0];
          v_r[j+1]   <= v_r[j];
        end
      end
    end
  end

  // ---------------- dividers ----------------
  logic [rmq_pkg::DIV_QBITS-1:0] quot_w [3];
  logic                          ovf_w  [3];

  for (genvar k = 0; k < 3; k++) begin : g_div
    rmq_div #(
      .FRAC_BITS (FRAC_BITS),
      .SW        (SW)
    ) u_div (
      .clk  (clk),
      .en   (adv),
      .mag  (mag_r[SW][k]),
      .root (root_r[SW]),
      .quot (quot_w[k]),
      .ovf  (ovf_w[k])
    );
  end

  logic [DL-1:0] vld2_r;
  logic [1:0]    cs2_r   [1:DL];
  logic          rz2_r   [1:DL];
  logic [2:0]    neg2_r  [1:DL];
  logic [SW-1:0] s2_r    [1:DL];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld2_r <= '0;
    end else if (adv) begin
      vld2_r <= {vld2_r[DL-2:0], vld_r[SW]};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cs2_r[1]  <= cs_r[SW];
      rz2_r[1]  <= rz_r[SW];
      neg2_r[1] <= neg_r[SW];
      s2_r[1]   <= root_r[SW];
      for (int i = 2; i <= DL; i++) begin
        cs2_r[i]  <= cs2_r[i-1];
        rz2_r[i]  <= rz2_r[i-1];
        neg2_r[i] <= neg2_r[i-1];
        s2_r[i]   <= s2_r[i-1];
      end
    end
  end

  // ---------------- saturation and placement ----------------
  logic [FW-1:0] q_nxt [4];
  logic          sat_nxt;

  always_comb begin
    logic [FW-1:0] oth [3];
    logic [FW-1:0] lead;
    logic [SW-2:0] half;
    logic          sat;
    sat  = 1'b0;
    half = s2_r[DL][SW-1:1];
    if (half > (SW-1)'(32767)) begin
      lead = 16'h7fff;
      sat  = 1'b1;
    end else begin
      lead = half[FW-1:0];
    end
    for (int k = 0; k < 3; k++) begin
      if (neg2_r[DL][k]) begin
        if (ovf_w[k] || quot_w[k] > 17'd32768) begin
          oth[k] = 16'h8000;
          sat    = 1'b1;
        end else begin
          oth[k] = FW'(-quot_w[k]);
        end
      end else begin
        if (ovf_w[k] || quot_w[k] > 17'd32767) begin
          oth[k] = 16'h7fff;
          sat    = 1'b1;
        end else begin
          oth[k] = quot_w[k][FW-1:0];
        end
      end
    end
    if (s2_r[DL] == '0) begin
      for (int k = 0; k < 3; k++) oth[k] = '0;
      sat = 1'b1;
    end
    case (cs2_r[DL])
      rmq_pkg::CASE_TRACE: begin
        q_nxt[0] = oth[0]; q_nxt[1] = oth[1]; q_nxt[2] = oth[2]; q_nxt[3] = lead;
      end
      rmq_pkg::CASE_X: begin
        q_nxt[0] = lead; q_nxt[1] = oth[1]; q_nxt[2] = oth[2]; q_nxt[3] = oth[0];
      end
      rmq_pkg::CASE_Y: begin
        q_nxt[0] = oth[1]; q_nxt[1] = lead; q_nxt[2] = oth[2]; q_nxt[3] = oth[0];
      end
      default: begin
        q_nxt[0] = oth[1]; q_nxt[1] = oth[2]; q_nxt[2] = lead; q_nxt[3] = oth[0];
      end
    endcase
    if (rz2_r[DL]) begin
      for (int k = 0; k < 4; k++) q_nxt[k] = '0;
      sat = 1'b1;
    end
    sat_nxt = sat;
  end

  logic        out_vld_r;
  logic [63:0] out_data_r;
  logic [2:0]  out_user_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= vld2_r[DL-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= {q_nxt[3], q_nxt[2], q_nxt[1], q_nxt[0]};
      out_user_r <= {sat_nxt, cs2_r[DL]};
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

`ifndef ASSERT_OFF
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> vld_r[0])
    else $error("accepted beat did not enter the pipe");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_r) && $stable(vld2_r))
    else $error("pipe moved during a stall");
  a_lead: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1:0] == rmq_pkg::CASE_TRACE |-> !out_tdata[63])
    else $error("leading w component negative");
`endif

endmodule

/* tb/rotation_matrix_to_quaternion_checker.sv */
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_checker: quaternion predictor and comparator
// Watches both streams, computes the expected quaternion for every accepted
// matrix beat and compares each output beat against the oldest prediction.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [143:0] in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [63:0]  out_tdata,
  input  logic [2:0]   out_tuser,
  output int           fail_count,
  output int           pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FB = rmq_pkg::FRAC_BITS_DEF;

  typedef struct packed {
    logic       sat;
    logic [1:0] cs;
    logic [63:0] q;
  } quat_t;

  quat_t quat_q[$];

  initial fail_count = 0;
  assign pending = quat_q.size();

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint clip(longint v, inout logic sat);
    if (v > 32767) begin sat = 1; return 32767; end
    if (v < -32768) begin sat = 1; return -32768; end
    return v;
  endfunction

  // n * 2^FB / d, nearest, ties away from zero
  function automatic longint round_div(longint n, longint d, inout logic sat);
    longint unsigned mag, qt;
    mag = (n < 0) ? -n : n;
    qt = ((mag << (FB + 1)) + d) / (d * 2);
    if (qt > 40000) qt = 40000;
    return clip((n < 0) ? -longint'(qt) : longint'(qt), sat);
  endfunction

  function automatic quat_t convert(logic [143:0] m);
    longint e[9];
    longint t, r, s, d, one;
    longint q[4];
    longint n[3];
    int lead, oth[3];
    logic [1:0] cs;
    logic sat;
    quat_t res;
    for (int i = 0; i < 9; i++) e[i] = longint'($signed(m[16*i +: 16]));
    // e: 0 xx 1 xy 2 xz 3 yx 4 yy 5 yz 6 zx 7 zy 8 zz
    one = longint'(1) << FB;
    t = e[0] + e[4] + e[8];
    sat = 0;
    q = '{0, 0, 0, 0};
    if (t > 0) begin
      cs = rmq_pkg::CASE_TRACE; r = one + t; lead = 3;
      oth = '{0, 1, 2}; n = '{e[5] - e[7], e[6] - e[2], e[1] - e[3]};
    end else if (e[0] > e[4] && e[0] > e[8]) begin
      cs = rmq_pkg::CASE_X; r = one + e[0] - e[4] - e[8]; lead = 0;
      oth = '{3, 1, 2}; n = '{e[5] - e[7], e[3] + e[1], e[6] + e[2]};
    end else if (e[4] > e[8]) begin
      cs = rmq_pkg::CASE_Y; r = one + e[4] - e[0] - e[8]; lead = 1;
      oth = '{3, 0, 2}; n = '{e[6] - e[2], e[3] + e[1], e[7] + e[5]};
    end else begin
      cs = rmq_pkg::CASE_Z; r = one + e[8] - e[0] - e[4]; lead = 2;
      oth = '{3, 0, 1}; n = '{e[1] - e[3], e[6] + e[2], e[7] + e[5]};
    end
    if (r <= 0) begin
      sat = 1;
    end else begin
      s = longint'(int_sqrt(longint'(r) << FB));
      d = 2 * s;
      q[lead] = clip(s >>> 1, sat);
      if (d == 0) sat = 1;
      else for (int i = 0; i < 3; i++) q[oth[i]] = round_div(n[i], d, sat);
    end
    for (int i = 0; i < 4; i++) res.q[16*i +: 16] = q[i][15:0];
    res.cs = cs;
    res.sat = sat;
    return res;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("MISMATCH %s got %0d want %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  always @(posedge clk) begin
    quat_t want;
    if (rst_n && in_tvalid && in_tready) quat_q = {quat_q, convert(in_tdata)};
    if (rst_n && out_tvalid && out_tready) begin
      if (quat_q.size() == 0) begin
        report("unexpected beat", 0, 0);
      end else begin
        want = quat_q.pop_front();
        for (int i = 0; i < 4; i++)
          if (out_tdata[16*i +: 16] !== want.q[16*i +: 16])
            report($sformatf("quat[%0d]", i), $signed(out_tdata[16*i +: 16]),
                   $signed(want.q[16*i +: 16]));
        if (out_tuser[1:0] !== want.cs) report("case_used", out_tuser[1:0], want.cs);
        if (out_tuser[2] !== want.sat) report("saturated", out_tuser[2], want.sat);
      end
    end
  end
endmodule

/* tb/rotation_matrix_to_quaternion_test.sv */
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_test: stimulus and verdict
// Directed matrices (identity, half turns, extremes, diagonal ties), then
// near-rotation and raw random matrices with random stalls on both sides.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic signed [15:0] ONE = 16'sd16384;
  localparam int RAND_BEATS = 850;

  logic         clk, rst_n;
  logic         in_tvalid, in_tready;
  logic [143:0] in_tdata;
  logic         out_tvalid, out_tready;
  logic [63:0]  out_tdata;
  logic [2:0]   out_tuser;
  int           fail_count, pending;
  bit           calm;

  rotation_matrix_to_quaternion dut (.*);

  rotation_matrix_to_quaternion_checker chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("rotation_matrix_to_quaternion verification failed");
    $finish;
  end

  // random sink stalls in bursts, none in the calm tail
  initial begin
    int n;
    out_tready = 1;
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 4);
        out_tready <= 0;
        repeat (n) @(posedge clk);
      end
      out_tready <= 1;
    end
  end

  function automatic logic [143:0] mat(logic [15:0] xx, logic [15:0] xy, logic [15:0] xz,
                                       logic [15:0] yx, logic [15:0] yy, logic [15:0] yz,
                                       logic [15:0] zx, logic [15:0] zy, logic [15:0] zz);
    return {zz, zy, zx, yz, yy, yx, xz, xy, xx};
  endfunction

  task automatic send(logic [143:0] m);
    int n;
    if (!calm && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 4);
      in_tvalid <= 0;
      repeat (n) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata  <= m;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  function automatic logic [15:0] jitter(logic [15:0] base, int amp);
    return base + 16'($signed($urandom_range(0, 2 * amp)) - amp);
  endfunction

  initial begin
    logic [143:0] m;
    logic [15:0] a, b, c;
    int w;
    rst_n = 0; in_tvalid = 0; in_tdata = '0; calm = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed
    send(mat(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE));
    send(mat(ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE));
    send(mat(-ONE, 0, 0, 0, ONE, 0, 0, 0, -ONE));
    send(mat(-ONE, 0, 0, 0, -ONE, 0, 0, 0, ONE));
    send(mat(0, ONE, 0, -ONE, 0, 0, 0, 0, ONE));
    send('0);
    send({9{16'h7fff}});
    send({9{16'h8000}});
    send({9{16'hffff}});
    send(mat(16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
             16'h7fff, 16'h8000, 16'h7fff, 16'h8000));
    send(mat(16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000,
             16'h7fff, 16'h8000, 16'h8000, 16'h7fff));
    send(mat(-ONE, 16'h7fff, 16'h7fff, 16'h8000, -ONE, 16'h7fff, 16'h8000,
             16'h8000, -ONE));
    send(mat(16'h8000, 1, 2, 3, 16'h8000, 4, 5, 6, 16'h7fff));
    send(mat(-100, 5, 6, 7, -100, 8, 9, 10, -200));
    send(mat(-200, 5, 6, 7, -100, 8, 9, 10, -100));
    send(mat(-ONE, 0, 0, 0, 0, 0, 0, 0, ONE));
    send(mat(1, 16'h7fff, 16'h8000, 16'h8000, 0, 16'h7fff, 16'h7fff, 16'h8000, 0));
    send(mat(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h8000,
             16'h8000, 16'h8000, 16'h8000));
    // random: half near-rotations (signed diagonals plus noise), the rest raw or with diagonal ties
    for (int i = 0; i < RAND_BEATS; i++) begin
      if (i > RAND_BEATS - 100) calm = 1;
      w = $urandom_range(0, 9);
      if (w < 3) begin
        m = {$urandom, $urandom, $urandom, $urandom, $urandom};
      end else if (w < 5) begin
        a = $urandom_range(0, 40000); b = $urandom_range(0, 40000); c = $urandom;
        m = mat(a, $urandom, $urandom, $urandom, b, $urandom, $urandom, $urandom, c);
        if ($urandom_range(0, 1)) m[16*4 +: 16] = m[0 +: 16];
        if ($urandom_range(0, 1)) m[16*8 +: 16] = m[16*4 +: 16];
      end else begin
        a = $urandom_range(0, 1) ? ONE : -ONE;
        b = $urandom_range(0, 1) ? ONE : -ONE;
        c = $urandom_range(0, 1) ? ONE : -ONE;
        m = mat(jitter(a, 12000), jitter(0, 12000), jitter(0, 12000),
                jitter(0, 12000), jitter(b, 12000), jitter(0, 12000),
                jitter(0, 12000), jitter(0, 12000), jitter(c, 12000));
      end
      send(m);
    end
    in_tvalid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("rotation_matrix_to_quaternion verification clean");
    end else begin
      $display("rotation_matrix_to_quaternion verification failed");
    end
    $finish;
  end
endmodule
